>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg)
`define CHK_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> hw/rtl/cob_pkg.sv
package cob_pkg;

  localparam int unsigned ALPHA    = 52;
  localparam int unsigned HALF     = 26;
  localparam int unsigned MAX_LINE = 64;
  localparam int unsigned SYM_W    = 6;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned ADDR_W   = 6;
  localparam int unsigned CNT_W    = 7;

  localparam logic [7:0] CHR_LO_A = 8'h61;
  localparam logic [7:0] CHR_LO_Z = 8'h7a;
  localparam logic [7:0] CHR_UP_A = 8'h41;
  localparam logic [7:0] CHR_UP_Z = 8'h5a;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] sym;
  } sym_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_ERR
  } state_e;

  function automatic sym_t to_sym(input logic [7:0] ch);
    sym_t r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (ch >= CHR_LO_A && ch <= CHR_LO_Z) begin
      t = ch - CHR_LO_A;
      r.ok = 1'b1;
      r.sym = t[SYM_W-1:0];
    end else if (ch >= CHR_UP_A && ch <= CHR_UP_Z) begin
      t = ch - CHR_UP_A + 8'(HALF);
      r.ok = 1'b1;
      r.sym = t[SYM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] to_ascii(input logic [SYM_W-1:0] sym);
    logic [7:0] r;
    if (sym < SYM_W'(HALF)) begin
      r = CHR_LO_A + {2'b00, sym};
    end else begin
      r = CHR_UP_A + {2'b00, sym} - 8'(HALF);
    end
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] mod_add(input logic [SYM_W:0] s);
    logic [SYM_W:0] r;
    r = (s >= (SYM_W+1)'(ALPHA)) ? s - (SYM_W+1)'(ALPHA) : s;
    return r[SYM_W-1:0];
  endfunction

endpackage

>>> hw/rtl/caesar_offset_breaker.sv
// Channel  | Dir | tdata (low bit up)                     | tuser     | tlast
// s_axis   | in  | cipher_char[7:0], guess_char[7:0]      | -         | last_pair
// m_axis   | out | plain_char[7:0], chosen_offset[5:0], 0 | bad_input | last_out
//
// A stored pair reads its histogram entry, then writes it back incremented.
// After the last pair the offset scan reads every histogram entry in turn.
// Each result then takes a cipher store read, then an output load.
// Reset clears control state and the histogram valid bits; no clearing pass is needed.
// A stall on m_axis holds the sequencer; s_axis is ready except during the histogram
// write and from the last pair until the final word is loaded.
module caesar_offset_breaker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cipher_char, guess_char
  input  logic        s_axis_tlast,   // last_pair
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // plain_char, chosen_offset, zero pad
  output logic        m_axis_tuser,   // bad_input
  output logic        m_axis_tlast    // last_out
);
  import cob_pkg::*;

  state_e state_q, state_d;

  logic [LEN_W-1:0]  len_q, len_d;
  logic              err_q, err_d;
  logic              last_q, last_d;
  logic [SYM_W-1:0]  d_q, d_d;
  logic [SYM_W-1:0]  scan_k_q, scan_k_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [SYM_W-1:0]  cmp_k_q;
  logic [SYM_W-1:0]  best_q, best_d;
  logic [CNT_W-1:0]  best_cnt_q, best_cnt_d;
  logic [LEN_W-1:0]  emit_idx_q, emit_idx_d;

  logic [CNT_W-1:0]  hist_mem [ALPHA];
  logic [ALPHA-1:0]  hist_vld_q;
  logic [CNT_W-1:0]  hist_rd_q;
  logic              hist_rv_q;
  logic [SYM_W-1:0]  hist_raddr;
  logic              hist_we;
  logic [CNT_W-1:0]  hist_wdata;
  logic              hist_clr;
  logic [CNT_W-1:0]  hist_cnt;

  logic [SYM_W-1:0]  cs_mem [2**ADDR_W];
  logic [SYM_W-1:0]  cs_rd_q;
  logic              cs_we;

  logic              out_vld_q, out_vld_d;
  logic [7:0]        out_plain_q;
  logic [SYM_W-1:0]  out_off_q;
  logic              out_bad_q;
  logic              out_last_q;
  logic              out_load;
  logic              out_free;
  logic [7:0]        load_plain;
  logic [SYM_W-1:0]  load_off;
  logic              load_bad;
  logic              load_last;

  sym_t              c_in, g_in;
  logic              pair_ok;
  logic              do_store;
  logic              acc;
  logic [SYM_W:0]    diff_sum;
  logic [SYM_W-1:0]  d_in;
  logic              emit_last;
  logic              in_emit;

  assign c_in     = to_sym(s_axis_tdata[7:0]);
  assign g_in     = to_sym(s_axis_tdata[15:8]);
  assign pair_ok  = c_in.ok && g_in.ok;
  assign do_store = pair_ok && (len_q < LEN_W'(MAX_LINE));
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign diff_sum = {1'b0, g_in.sym} + (SYM_W+1)'(ALPHA) - {1'b0, c_in.sym};
  assign d_in     = mod_add(diff_sum);
  assign hist_cnt = hist_rv_q ? hist_rd_q : '0;
  assign emit_last = (emit_idx_q + LEN_W'(1)) == len_q;
  assign out_free = !out_vld_q || m_axis_tready;
  assign in_emit  = (state_q == ST_EMIT_RD) || (state_q == ST_EMIT_OUT);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_off_q, out_plain_q};
  assign m_axis_tuser  = out_bad_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    err_d      = err_q;
    last_d     = last_q;
    d_d        = d_q;
    scan_k_d   = scan_k_q;
    cmp_vld_d  = 1'b0;
    best_d     = best_q;
    best_cnt_d = best_cnt_q;
    emit_idx_d = emit_idx_q;
    hist_raddr = d_in;
    hist_we    = 1'b0;
    hist_wdata = hist_cnt + CNT_W'(1);
    hist_clr   = 1'b0;
    cs_we      = 1'b0;
    out_load   = 1'b0;
    load_plain = '0;
    load_off   = '0;
    load_bad   = 1'b0;
    load_last  = 1'b1;

    if (cmp_vld_q && (hist_cnt > best_cnt_q)) begin
      best_d     = cmp_k_q;
      best_cnt_d = hist_cnt;
    end

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          err_d  = err_q || !pair_ok;
          last_d = s_axis_tlast;
          if (do_store) begin
            cs_we   = 1'b1;
            d_d     = d_in;
            len_d   = len_q + LEN_W'(1);
            state_d = ST_UPD;
          end else if (s_axis_tlast) begin
            if (err_q || !pair_ok || (len_q == '0)) begin
              state_d = ST_ERR;
            end else begin
              scan_k_d   = '0;
              best_d     = '0;
              best_cnt_d = '0;
              state_d    = ST_SCAN;
            end
          end
        end
      end
      ST_UPD: begin
        hist_we = 1'b1;
        if (last_q) begin
          if (err_q) begin
            state_d = ST_ERR;
          end else begin
            scan_k_d   = '0;
            best_d     = '0;
            best_cnt_d = '0;
            state_d    = ST_SCAN;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        hist_raddr = scan_k_q;
        cmp_vld_d  = 1'b1;
        scan_k_d   = scan_k_q + SYM_W'(1);
        if (scan_k_q == SYM_W'(ALPHA - 1)) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        emit_idx_d = '0;
        state_d    = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        load_plain = to_ascii(mod_add({1'b0, cs_rd_q} + {1'b0, best_q}));
        load_off   = best_q;
        load_last  = emit_last;
        if (out_free) begin
          out_load = 1'b1;
          if (emit_last) begin
            len_d    = '0;
            err_d    = 1'b0;
            hist_clr = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + LEN_W'(1);
            state_d    = ST_EMIT_RD;
          end
        end
      end
      ST_ERR: begin
        load_bad = err_q;
        if (out_free) begin
          out_load = 1'b1;
          len_d    = '0;
          err_d    = 1'b0;
          hist_clr = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      len_q      <= '0;
      err_q      <= 1'b0;
      last_q     <= 1'b0;
      scan_k_q   <= '0;
      cmp_vld_q  <= 1'b0;
      best_q     <= '0;
      best_cnt_q <= '0;
      emit_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      err_q      <= err_d;
      last_q     <= last_d;
      scan_k_q   <= scan_k_d;
      cmp_vld_q  <= cmp_vld_d;
      best_q     <= best_d;
      best_cnt_q <= best_cnt_d;
      emit_idx_q <= emit_idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    cmp_k_q <= scan_k_q;
    if (out_load) begin
      out_plain_q <= load_plain;
      out_off_q   <= load_off;
      out_bad_q   <= load_bad;
      out_last_q  <= load_last;
    end
  end

  // Histogram memory: one read and one write port.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[d_q] <= hist_wdata;
    end
    hist_rd_q <= hist_mem[hist_raddr];
    hist_rv_q <= hist_vld_q[hist_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
    end else if (hist_clr) begin
      hist_vld_q <= '0;
    end else if (hist_we) begin
      hist_vld_q[d_q] <= 1'b1;
    end
  end

  // Cipher store: written at the line position, read during emit.
  always_ff @(posedge clk_i) begin
    if (cs_we) begin
      cs_mem[len_q[ADDR_W-1:0]] <= c_in.sym;
    end
    cs_rd_q <= cs_mem[emit_idx_q[ADDR_W-1:0]];
  end

`include "assert_macros.svh"

  `CHK_NEVER(a_best_range, clk_i, rst_ni, best_q > SYM_W'(ALPHA - 1), "offset out of range")
  `CHK_NEVER(a_len_max, clk_i, rst_ni, len_q > LEN_W'(MAX_LINE), "line length overflow")
  `CHK_ASSERT(a_emit_idx, clk_i, rst_ni, in_emit |-> (emit_idx_q < len_q), "emit index past line")
  `CHK_ASSERT(a_bad_last, clk_i, rst_ni, out_vld_q && out_bad_q |-> out_last_q, "error word not last")
  `CHK_ASSERT(a_upd_from_idle, clk_i, rst_ni, state_q == ST_UPD |-> $past(acc), "update without word")

endmodule

>>> tb/cob_tb_pkg.sv
`timescale 1ns / 100ps
package cob_tb_pkg;
  import cob_pkg::*;

  typedef struct packed {
    logic [7:0] plain_char;
    logic [5:0] offset;
    logic       bad_input;
    logic       last_out;
  } letter_t;

  function automatic bit letter_to_index(input logic [7:0] ch, output logic [5:0] idx);
    int code;
    code = int'(ch);
    idx = '0;
    if (code >= int'(CHR_LO_A) && code <= int'(CHR_LO_Z)) begin
      idx = 6'(code - int'(CHR_LO_A));
      return 1'b1;
    end
    if (code >= int'(CHR_UP_A) && code <= int'(CHR_UP_Z)) begin
      idx = 6'(code - int'(CHR_UP_A) + int'(HALF));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] index_to_letter(input int unsigned idx);
    if (idx < HALF) begin
      return 8'(int'(CHR_LO_A) + idx);
    end
    return 8'(int'(CHR_UP_A) + idx - HALF);
  endfunction

  class offset_scoreboard;
    logic [6:0]  shift_count [ALPHA];
    logic [5:0]  line_text [MAX_LINE];
    int unsigned line_len;
    bit          bad_seen;
    letter_t     expected_letters [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (shift_count[k]) begin
        shift_count[k] = '0;
      end
      line_len = 0;
      bad_seen = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_letters.size();
    endfunction

    function void note_pair(logic [7:0] cipher, logic [7:0] guess, logic last_pair);
      logic [5:0]  ci;
      logic [5:0]  gi;
      bit          ok_c;
      bit          ok_g;
      int unsigned shift;
      int unsigned best;
      letter_t     r;
      ok_c = letter_to_index(cipher, ci);
      ok_g = letter_to_index(guess, gi);
      if (!(ok_c && ok_g)) begin
        bad_seen = 1'b1;
      end else if (line_len < MAX_LINE) begin
        shift = (int'(gi) + ALPHA - int'(ci)) % ALPHA;
        line_text[line_len] = ci;
        shift_count[shift] = shift_count[shift] + 7'd1;
        line_len++;
      end
      if (!last_pair) begin
        return;
      end
      if (bad_seen || line_len == 0) begin
        r.plain_char = 8'h00;
        r.offset     = '0;
        r.bad_input  = bad_seen;
        r.last_out   = 1'b1;
        expected_letters.push_back(r);
      end else begin
        // strict compare keeps the lowest shift on ties
        best = 0;
        for (int unsigned k = 1; k < ALPHA; k++) begin
          if (shift_count[k] > shift_count[best]) begin
            best = k;
          end
        end
        for (int unsigned k = 0; k < line_len; k++) begin
          r.plain_char = index_to_letter((int'(line_text[k]) + best) % ALPHA);
          r.offset     = 6'(best);
          r.bad_input  = 1'b0;
          r.last_out   = (k == line_len - 1);
          expected_letters.push_back(r);
        end
      end
      clear_line();
    endfunction

    task report(string msg);
      if (mismatches < 100) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    task check_letter(logic [15:0] data, logic bad_input, logic last_out);
      letter_t e;
      if (expected_letters.size() == 0) begin
        report($sformatf("unexpected word data=%h user=%b last=%b", data, bad_input, last_out));
        return;
      end
      e = expected_letters.pop_front();
      if (data[7:0] !== e.plain_char) begin
        report($sformatf("plain_char %h, want %h", data[7:0], e.plain_char));
      end
      if (data[13:8] !== e.offset) begin
        report($sformatf("chosen_offset %0d, want %0d", data[13:8], e.offset));
      end
      if (bad_input !== e.bad_input) begin
        report($sformatf("bad_input %b, want %b", bad_input, e.bad_input));
      end
      if (last_out !== e.last_out) begin
        report($sformatf("last_out %b, want %b", last_out, e.last_out));
      end
    endtask
  endclass

endpackage

>>> tb/caesar_offset_breaker_tb.sv
`timescale 1ns / 100ps
module caesar_offset_breaker_tb;
  import cob_pkg::*;
  import cob_tb_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PAIR_TARGET  = 500;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // cipher_char, guess_char
  logic        s_axis_tlast  = 1'b0; // last_pair
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // plain_char, chosen_offset, zero pad
  logic        m_axis_tuser;         // bad_input
  logic        m_axis_tlast;         // last_out

  offset_scoreboard letters_sb = new();
  int unsigned      tx_gap_max = 0;
  int unsigned      rx_gap_max = 0;
  int unsigned      pairs_sent = 0;
  int unsigned      idle_cycles = 0;

  caesar_offset_breaker u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned gap_bound();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 2;
      default: return 16;
    endcase
  endfunction

  task automatic send_pair(input logic [7:0] cipher, input logic [7:0] guess,
                           input logic last_pair);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {guess, cipher};
    s_axis_tlast  <= last_pair;
    do @(posedge clk_i); while (!s_axis_tready);
    letters_sb.note_pair(cipher, guess, last_pair);
  endtask

  task automatic send_line(input int unsigned len, input int unsigned shift,
                           input int unsigned noise_pct);
    int unsigned ci;
    logic [7:0]  cipher;
    logic [7:0]  guess;
    for (int unsigned i = 0; i < len; i++) begin
      ci = $urandom_range(0, ALPHA - 1);
      cipher = index_to_letter(ci);
      if ($urandom_range(0, 3) != 0) begin
        guess = index_to_letter((ci + shift) % ALPHA);
      end else begin
        guess = index_to_letter($urandom_range(0, ALPHA - 1));
      end
      if ($urandom_range(0, 99) < noise_pct) begin
        cipher = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < noise_pct) begin
        guess = 8'($urandom_range(0, 255));
      end
      send_pair(cipher, guess, i == len - 1);
      if (i < MAX_LINE) begin
        pairs_sent++;
      end
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pair("a", "a", 1'b1);
    // wrap z->A and Z->a
    send_pair("z", "A", 1'b0);
    send_pair("Z", "a", 1'b1);
    // tie between shift 1 and shift 51
    send_pair("a", "b", 1'b0);
    send_pair("b", "a", 1'b1);
    send_pair("A", "z", 1'b1);
    send_pair(8'h00, "a", 1'b0);
    send_pair("b", "c", 1'b1);
    send_pair("@", "a", 1'b0);
    send_pair("a", 8'h60, 1'b0);
    send_pair("[", "Z", 1'b0);
    send_pair("Z", "{", 1'b1);
    send_pair(8'hFF, 8'h00, 1'b1);
    send_pair("m", "Q", 1'b0);
    send_pair("q", "U", 1'b0);
    send_pair("Y", "C", 1'b0);
    send_pair("k", "n", 1'b1);
    while (pairs_sent < PAIR_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        len = $urandom_range(MAX_LINE + 1, MAX_LINE + 6);
      end else if (pick == 1) begin
        len = $urandom_range(33, MAX_LINE);
      end else begin
        len = $urandom_range(1, 12);
      end
      tx_gap_max = gap_bound();
      send_line(len, $urandom_range(0, ALPHA - 1), ($urandom_range(0, 4) == 0) ? 10 : 0);
    end
    s_axis_tvalid <= 1'b0;
    while (letters_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (letters_sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      letters_sb.check_letter(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (m_axis_tlast) begin
        rx_gap_max = gap_bound();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cob_pkg.sv
hw/rtl/caesar_offset_breaker.sv
tb/cob_tb_pkg.sv
tb/caesar_offset_breaker_tb.sv
